// ===== rtl/ofd_pkg.sv =====
// Shared constants, types and helpers for the orthonormal frame pipeline.
// No dependencies; every other file imports this package.
package ofd_pkg;

    localparam int DATA_W            = 32;   // component width, in and out
    localparam int ACC_W             = 64;   // squares, sums, dividends
    localparam int ROOT_W            = ACC_W / 2;
    localparam int DEN_W             = ROOT_W + 1;
    localparam int MIN_LEN_W         = 17;
    localparam int IN_FRAC_BITS_DEF  = 16;
    localparam int OUT_FRAC_BITS_DEF = 30;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = MIN_LEN_W'(1);

    // Reference axis switch: |up.y| * RefDen > RefNum * one
    localparam logic [ACC_W-1:0] RefNum = ACC_W'(999);
    localparam logic [ACC_W-1:0] RefDen = ACC_W'(1000);

    typedef logic signed [DATA_W-1:0] comp_t;
    typedef logic [DATA_W-1:0]        mag_t;
    typedef logic [ACC_W-1:0]         acc_t;

    // Magnitude of a signed component; the most negative value maps to 2^31.
    function automatic mag_t mag_f(input comp_t v);
        mag_t m;
        m = v[DATA_W-1] ? mag_t'(-v) : mag_t'(v);
        return m;
    endfunction

endpackage

// ===== rtl/ofd_dir_if.sv =====
// Input channel: one direction vector per transaction.
// Depends on ofd_pkg for the component type.
interface ofd_dir_if
    import ofd_pkg::*;
();
    logic  valid;
    logic  ready;
    comp_t dir_x;
    comp_t dir_y;
    comp_t dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

// ===== rtl/ofd_frame_if.sv =====
// Output channel: one orientation frame (three rows) per transaction.
// Depends on ofd_pkg for the component type.
interface ofd_frame_if
    import ofd_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  valid_res;
    comp_t right_x;
    comp_t right_y;
    comp_t right_z;
    comp_t up_x;
    comp_t up_y;
    comp_t up_z;
    comp_t fwd_x;
    comp_t fwd_y;
    comp_t fwd_z;

    modport source (
        output valid, output valid_res,
        output right_x, output right_y, output right_z,
        output up_x, output up_y, output up_z,
        output fwd_x, output fwd_y, output fwd_z,
        input ready
    );
    modport sink (
        input valid, input valid_res,
        input right_x, input right_y, input right_z,
        input up_x, input up_y, input up_z,
        input fwd_x, input fwd_y, input fwd_z,
        output ready
    );
endinterface

// ===== rtl/ofd_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband word alongside; depends on ofd_pkg for the default input width.
module ofd_sqrt
    import ofd_pkg::*;
#(
    parameter int IN_W   = ACC_W,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [IN_W-1:0]       in_val,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_vld,
    output logic [IN_W/2-1:0]     out_root,
    output logic [SIDE_W-1:0]     out_side
);
    localparam int RW    = IN_W / 2;
    localparam int REM_W = RW + 2;

    logic              vld_reg  [RW];
    logic [IN_W-1:0]   rad_reg  [RW];
    logic [REM_W-1:0]  rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [SIDE_W-1:0] side_reg [RW];

    genvar s;
    for (s = 0; s < RW; s++)
    begin : g_stg
        logic              vld_prev;
        logic [IN_W-1:0]   rad_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [RW-1:0]     root_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  cmp;
        logic [REM_W-1:0]  rem_next;
        logic [RW-1:0]     root_next;

        if (s == 0)
        begin : g_first
            assign vld_prev  = in_vld;
            assign rad_prev  = in_val;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = in_side;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[s-1];
            assign rad_prev  = rad_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign root_prev = root_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        // Bring down the next two radicand bits and try 4*root + 1
        always_comb
        begin
            trial = {rem_prev, rad_prev[IN_W-1-2*s -: 2]};
            cmp   = (REM_W+2)'({root_prev, 2'b01});
            if (trial >= cmp)
            begin
                rem_next  = REM_W'(trial - cmp);
                root_next = {root_prev[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(trial);
                root_next = {root_prev[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s]  <= rad_prev;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_vld  = vld_reg[RW-1];
    assign out_root = root_reg[RW-1];
    assign out_side = side_reg[RW-1];
endmodule

// ===== rtl/ofd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several
// dividends over one shared divisor. Depends on ofd_pkg for defaults.
module ofd_div
    import ofd_pkg::*;
#(
    parameter int LANES  = 3,
    parameter int NUM_W  = ACC_W,
    parameter int DEN_W  = ofd_pkg::DEN_W,
    parameter int QUO_W  = OUT_FRAC_BITS_DEF + 1,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  in_num [LANES],
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [QUO_W-1:0]  out_quo [LANES],
    output logic [SIDE_W-1:0] out_side
);
    logic              vld_reg  [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    logic [NUM_W-1:0]  num_reg  [QUO_W][LANES];
    logic [DEN_W-1:0]  rem_reg  [QUO_W][LANES];
    logic [QUO_W-1:0]  quo_reg  [QUO_W][LANES];

    genvar s, l;
    for (s = 0; s < QUO_W; s++)
    begin : g_stg
        logic              vld_prev;
        logic [DEN_W-1:0]  den_prev;
        logic [SIDE_W-1:0] side_prev;

        if (s == 0)
        begin : g_first
            assign vld_prev  = in_vld;
            assign den_prev  = in_den;
            assign side_prev = in_side;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[s-1];
            assign den_prev  = den_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[s]  <= den_prev;
                side_reg[s] <= side_prev;
            end
        end

        for (l = 0; l < LANES; l++)
        begin : g_lane
            logic [NUM_W-1:0] num_prev;
            logic [DEN_W-1:0] rem_prev;
            logic [QUO_W-1:0] quo_prev;
            logic [DEN_W:0]   trial;
            logic [DEN_W-1:0] rem_next;
            logic [QUO_W-1:0] quo_next;

            if (s == 0)
            begin : g_first
                assign num_prev = in_num[l];
                assign rem_prev = DEN_W'(in_num[l] >> QUO_W);
                assign quo_prev = '0;
            end
            else
            begin : g_rest
                assign num_prev = num_reg[s-1][l];
                assign rem_prev = rem_reg[s-1][l];
                assign quo_prev = quo_reg[s-1][l];
            end

            // Shift in the next dividend bit and subtract when it fits
            always_comb
            begin
                trial = {rem_prev, num_prev[QUO_W-1-s]};
                if (trial >= {1'b0, den_prev})
                begin
                    rem_next = DEN_W'(trial - {1'b0, den_prev});
                    quo_next = {quo_prev[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = DEN_W'(trial);
                    quo_next = {quo_prev[QUO_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[s][l] <= num_prev;
                    rem_reg[s][l] <= rem_next;
                    quo_reg[s][l] <= quo_next;
                end
            end
        end
    end

    for (l = 0; l < LANES; l++)
    begin : g_out
        assign out_quo[l] = quo_reg[QUO_W-1][l];
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign out_side = side_reg[QUO_W-1];
endmodule

// ===== rtl/orthonormal_frame_from_direction.sv =====
// Orthonormal frame builder: direction vector in, rows right/up/forward out.
// Depends on ofd_pkg, ofd_dir_if, ofd_frame_if, ofd_sqrt and ofd_div.
//
// Usage:
//   dir_in carries one signed Q16.16 direction (dir_x, dir_y, dir_z) per
//   transaction. frame_out returns one frame per input in signed Q2.30:
//   valid_res, right_*, up_*, fwd_*. valid_res is 0 and every row is zero
//   when the input length or the length of right is below min_length.
//   min_length is written through cfg_wr_en / cfg_wr_data (17 bits,
//   unsigned Q1.16); write it only while the pipeline is empty.
// Throughput: one transaction per cycle while frame_out is taken.
// Pipeline: three 32-stage square roots, three (OUT_FRAC_BITS+1)-stage
//   dividers and 17 stages of multiply, add and select.
// Reset: all pipeline valid bits clear, min_length returns to 1.
// Stall: when frame_out is not taken the whole pipeline holds and
//   dir_in.ready drops; nothing is lost or repeated.
module orthonormal_frame_from_direction
    import ofd_pkg::*;
#(
    parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [MIN_LEN_W-1:0] cfg_wr_data,
    ofd_dir_if.sink              dir_in,
    ofd_frame_if.source          frame_out
);
    localparam int QUO_W = OUT_FRAC_BITS + 1;
    localparam logic [QUO_W-1:0] OneQ = QUO_W'(1) << OUT_FRAC_BITS;
    localparam acc_t HalfOut = acc_t'(1) << (OUT_FRAC_BITS - 1);

    // Clamp a quotient to one and apply the sign
    function automatic comp_t apply_sign(input logic [QUO_W-1:0] q, input logic neg);
        logic [QUO_W-1:0] qc;
        comp_t            v;
        qc = (q > OneQ) ? OneQ : q;
        v  = comp_t'(qc);
        return neg ? -v : v;
    endfunction

    logic adv;
    logic [MIN_LEN_W-1:0] min_len_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            min_len_reg <= cfg_wr_data;
        end
    end

    // ---------------- input length ----------------
    logic  s1_vld_reg, s2_vld_reg, s3_vld_reg;
    comp_t s1_d_reg [3];
    comp_t s2_d_reg [3];
    comp_t s3_d_reg [3];
    acc_t  s2_sq_reg [3];
    acc_t  s3_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= dir_in.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // Capture, square, sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_d_reg[0] <= dir_in.dir_x;
            s1_d_reg[1] <= dir_in.dir_y;
            s1_d_reg[2] <= dir_in.dir_z;
            for (int i = 0; i < 3; i++)
            begin
                s2_d_reg[i]  <= s1_d_reg[i];
                s2_sq_reg[i] <= acc_t'(mag_f(s1_d_reg[i])) * acc_t'(mag_f(s1_d_reg[i]));
                s3_d_reg[i]  <= s2_d_reg[i];
            end
            s3_sum_reg <= s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
        end
    end

    logic                  sa_vld;
    logic [ROOT_W-1:0]     sa_len;
    logic [3*DATA_W-1:0]   sa_side;

    ofd_sqrt #(.IN_W(ACC_W), .SIDE_W(3*DATA_W)) u_sqrt_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s3_vld_reg),
        .in_val   (s3_sum_reg),
        .in_side  ({s3_d_reg[0], s3_d_reg[1], s3_d_reg[2]}),
        .out_vld  (sa_vld),
        .out_root (sa_len),
        .out_side (sa_side)
    );

    // ---------------- normalize up ----------------
    comp_t sa_d [3];
    assign sa_d[0] = sa_side[3*DATA_W-1 -: DATA_W];
    assign sa_d[1] = sa_side[2*DATA_W-1 -: DATA_W];
    assign sa_d[2] = sa_side[DATA_W-1 -: DATA_W];

    logic             s4_vld_reg, s4_bad_reg;
    logic [2:0]       s4_neg_reg;
    acc_t             s4_num_reg [3];
    logic [DEN_W-1:0] s4_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_vld_reg <= sa_vld;
        end
    end

    // Reject short input, build dividends
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_bad_reg <= (sa_len == '0) || (sa_len < ROOT_W'(min_len_reg));
            for (int i = 0; i < 3; i++)
            begin
                s4_neg_reg[i] <= sa_d[i][DATA_W-1];
                s4_num_reg[i] <= (acc_t'(mag_f(sa_d[i])) << (OUT_FRAC_BITS + 1)) + acc_t'(sa_len);
            end
            s4_den_reg <= {sa_len, 1'b0};
        end
    end

    logic             da_vld;
    logic [QUO_W-1:0] da_quo [3];
    logic [3:0]       da_side;

    ofd_div #(.LANES(3), .NUM_W(ACC_W), .DEN_W(DEN_W), .QUO_W(QUO_W), .SIDE_W(4)) u_div_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s4_vld_reg),
        .in_num   (s4_num_reg),
        .in_den   (s4_den_reg),
        .in_side  ({s4_bad_reg, s4_neg_reg}),
        .out_vld  (da_vld),
        .out_quo  (da_quo),
        .out_side (da_side)
    );

    // ---------------- right before normalization ----------------
    logic  s5_vld_reg, s6_vld_reg, s7_vld_reg, s8_vld_reg;
    logic  s5_bad_reg, s6_bad_reg, s7_bad_reg, s8_bad_reg;
    comp_t s5_u_reg [3];
    comp_t s6_u_reg [3];
    comp_t s7_u_reg [3];
    comp_t s8_u_reg [3];
    comp_t s6_rr_reg [3];
    comp_t s7_rr_reg [3];
    comp_t s8_rr_reg [3];
    acc_t  s7_sq_reg [3];
    acc_t  s8_sum_reg;
    logic  ref_x;

    assign ref_x = (acc_t'(mag_f(s5_u_reg[1])) * RefDen) > (RefNum << OUT_FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_vld_reg <= da_vld;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= s7_vld_reg;
        end
    end

    // Sign up, pick the reference axis, square and sum right
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_bad_reg <= da_side[3];
            for (int i = 0; i < 3; i++)
            begin
                s5_u_reg[i] <= apply_sign(da_quo[i], da_side[i]);
            end

            s6_bad_reg <= s5_bad_reg;
            s6_u_reg   <= s5_u_reg;
            if (ref_x)
            begin
                s6_rr_reg[0] <= '0;
                s6_rr_reg[1] <= -s5_u_reg[2];
                s6_rr_reg[2] <= s5_u_reg[1];
            end
            else
            begin
                s6_rr_reg[0] <= s5_u_reg[2];
                s6_rr_reg[1] <= '0;
                s6_rr_reg[2] <= -s5_u_reg[0];
            end

            s7_bad_reg <= s6_bad_reg;
            s7_u_reg   <= s6_u_reg;
            s7_rr_reg  <= s6_rr_reg;
            for (int i = 0; i < 3; i++)
            begin
                s7_sq_reg[i] <= acc_t'(mag_f(s6_rr_reg[i])) * acc_t'(mag_f(s6_rr_reg[i]));
            end

            s8_bad_reg <= s7_bad_reg;
            s8_u_reg   <= s7_u_reg;
            s8_rr_reg  <= s7_rr_reg;
            s8_sum_reg <= s7_sq_reg[0] + s7_sq_reg[1] + s7_sq_reg[2];
        end
    end

    localparam int SB_W = 1 + 6 * DATA_W;

    logic              sb_vld;
    logic [ROOT_W-1:0] sb_len;
    logic [SB_W-1:0]   sb_side;

    ofd_sqrt #(.IN_W(ACC_W), .SIDE_W(SB_W)) u_sqrt_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s8_vld_reg),
        .in_val   (s8_sum_reg),
        .in_side  ({s8_bad_reg, s8_u_reg[0], s8_u_reg[1], s8_u_reg[2],
                    s8_rr_reg[0], s8_rr_reg[1], s8_rr_reg[2]}),
        .out_vld  (sb_vld),
        .out_root (sb_len),
        .out_side (sb_side)
    );

    // ---------------- normalize right ----------------
    logic  sb_bad;
    comp_t sb_u [3];
    comp_t sb_rr [3];
    logic  short_right;

    assign sb_bad   = sb_side[SB_W-1];
    assign sb_u[0]  = sb_side[6*DATA_W-1 -: DATA_W];
    assign sb_u[1]  = sb_side[5*DATA_W-1 -: DATA_W];
    assign sb_u[2]  = sb_side[4*DATA_W-1 -: DATA_W];
    assign sb_rr[0] = sb_side[3*DATA_W-1 -: DATA_W];
    assign sb_rr[1] = sb_side[2*DATA_W-1 -: DATA_W];
    assign sb_rr[2] = sb_side[DATA_W-1 -: DATA_W];

    assign short_right = (sb_len == '0) ||
        ((acc_t'(sb_len) << IN_FRAC_BITS) < (acc_t'(min_len_reg) << OUT_FRAC_BITS));

    logic             s9_vld_reg, s9_bad_reg;
    logic [2:0]       s9_neg_reg;
    comp_t            s9_u_reg [3];
    acc_t             s9_num_reg [3];
    logic [DEN_W-1:0] s9_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s9_vld_reg <= sb_vld;
        end
    end

    // Reject short right, build dividends
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_bad_reg <= sb_bad || short_right;
            s9_u_reg   <= sb_u;
            for (int i = 0; i < 3; i++)
            begin
                s9_neg_reg[i] <= sb_rr[i][DATA_W-1];
                s9_num_reg[i] <= (acc_t'(mag_f(sb_rr[i])) << (OUT_FRAC_BITS + 1)) + acc_t'(sb_len);
            end
            s9_den_reg <= {sb_len, 1'b0};
        end
    end

    localparam int DB_W = 4 + 3 * DATA_W;

    logic             db_vld;
    logic [QUO_W-1:0] db_quo [3];
    logic [DB_W-1:0]  db_side;

    ofd_div #(.LANES(3), .NUM_W(ACC_W), .DEN_W(DEN_W), .QUO_W(QUO_W), .SIDE_W(DB_W)) u_div_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s9_vld_reg),
        .in_num   (s9_num_reg),
        .in_den   (s9_den_reg),
        .in_side  ({s9_bad_reg, s9_neg_reg, s9_u_reg[0], s9_u_reg[1], s9_u_reg[2]}),
        .out_vld  (db_vld),
        .out_quo  (db_quo),
        .out_side (db_side)
    );

    // ---------------- forward = up x right ----------------
    logic  s10_vld_reg, s11_vld_reg, s12_vld_reg, s13_vld_reg, s14_vld_reg, s15_vld_reg;
    logic  s10_bad_reg, s11_bad_reg, s12_bad_reg, s13_bad_reg, s14_bad_reg, s15_bad_reg;
    comp_t s10_u_reg [3];
    comp_t s11_u_reg [3];
    comp_t s12_u_reg [3];
    comp_t s13_u_reg [3];
    comp_t s14_u_reg [3];
    comp_t s15_u_reg [3];
    comp_t s10_r_reg [3];
    comp_t s11_r_reg [3];
    comp_t s12_r_reg [3];
    comp_t s13_r_reg [3];
    comp_t s14_r_reg [3];
    comp_t s15_r_reg [3];
    logic signed [ACC_W-1:0] s11_p_reg [6];
    logic signed [ACC_W-1:0] s12_e_reg [3];
    mag_t  s13_fm_reg [3];
    mag_t  s14_fm_reg [3];
    mag_t  s15_fm_reg [3];
    logic [2:0] s13_fn_reg, s14_fn_reg, s15_fn_reg;
    acc_t  s14_sq_reg [3];
    acc_t  s15_sum_reg;
    comp_t db_u [3];

    assign db_u[0] = db_side[3*DATA_W-1 -: DATA_W];
    assign db_u[1] = db_side[2*DATA_W-1 -: DATA_W];
    assign db_u[2] = db_side[DATA_W-1 -: DATA_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
            s13_vld_reg <= 1'b0;
            s14_vld_reg <= 1'b0;
            s15_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s10_vld_reg <= db_vld;
            s11_vld_reg <= s10_vld_reg;
            s12_vld_reg <= s11_vld_reg;
            s13_vld_reg <= s12_vld_reg;
            s14_vld_reg <= s13_vld_reg;
            s15_vld_reg <= s14_vld_reg;
        end
    end

    // Sign right, multiply, subtract, round, square, sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s10_bad_reg <= db_side[DB_W-1];
            s10_u_reg   <= db_u;
            for (int i = 0; i < 3; i++)
            begin
                s10_r_reg[i] <= apply_sign(db_quo[i], db_side[3*DATA_W+i]);
            end

            s11_bad_reg  <= s10_bad_reg;
            s11_u_reg    <= s10_u_reg;
            s11_r_reg    <= s10_r_reg;
            s11_p_reg[0] <= ACC_W'(s10_u_reg[1]) * ACC_W'(s10_r_reg[2]);
            s11_p_reg[1] <= ACC_W'(s10_u_reg[2]) * ACC_W'(s10_r_reg[1]);
            s11_p_reg[2] <= ACC_W'(s10_u_reg[2]) * ACC_W'(s10_r_reg[0]);
            s11_p_reg[3] <= ACC_W'(s10_u_reg[0]) * ACC_W'(s10_r_reg[2]);
            s11_p_reg[4] <= ACC_W'(s10_u_reg[0]) * ACC_W'(s10_r_reg[1]);
            s11_p_reg[5] <= ACC_W'(s10_u_reg[1]) * ACC_W'(s10_r_reg[0]);

            s12_bad_reg  <= s11_bad_reg;
            s12_u_reg    <= s11_u_reg;
            s12_r_reg    <= s11_r_reg;
            s12_e_reg[0] <= s11_p_reg[0] - s11_p_reg[1];
            s12_e_reg[1] <= s11_p_reg[2] - s11_p_reg[3];
            s12_e_reg[2] <= s11_p_reg[4] - s11_p_reg[5];

            s13_bad_reg <= s12_bad_reg;
            s13_u_reg   <= s12_u_reg;
            s13_r_reg   <= s12_r_reg;
            for (int i = 0; i < 3; i++)
            begin
                s13_fn_reg[i] <= s12_e_reg[i][ACC_W-1];
                s13_fm_reg[i] <= DATA_W'(((s12_e_reg[i][ACC_W-1] ? acc_t'(-s12_e_reg[i])
                                 : acc_t'(s12_e_reg[i])) + HalfOut) >> OUT_FRAC_BITS);
            end

            s14_bad_reg <= s13_bad_reg;
            s14_u_reg   <= s13_u_reg;
            s14_r_reg   <= s13_r_reg;
            s14_fm_reg  <= s13_fm_reg;
            s14_fn_reg  <= s13_fn_reg;
            for (int i = 0; i < 3; i++)
            begin
                s14_sq_reg[i] <= acc_t'(s13_fm_reg[i]) * acc_t'(s13_fm_reg[i]);
            end

            s15_bad_reg <= s14_bad_reg;
            s15_u_reg   <= s14_u_reg;
            s15_r_reg   <= s14_r_reg;
            s15_fm_reg  <= s14_fm_reg;
            s15_fn_reg  <= s14_fn_reg;
            s15_sum_reg <= s14_sq_reg[0] + s14_sq_reg[1] + s14_sq_reg[2];
        end
    end

    localparam int SC_W = 4 + 9 * DATA_W;

    logic              sc_vld;
    logic [ROOT_W-1:0] sc_len;
    logic [SC_W-1:0]   sc_side;

    ofd_sqrt #(.IN_W(ACC_W), .SIDE_W(SC_W)) u_sqrt_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s15_vld_reg),
        .in_val   (s15_sum_reg),
        .in_side  ({s15_bad_reg, s15_fn_reg,
                    s15_u_reg[0], s15_u_reg[1], s15_u_reg[2],
                    s15_r_reg[0], s15_r_reg[1], s15_r_reg[2],
                    s15_fm_reg[0], s15_fm_reg[1], s15_fm_reg[2]}),
        .out_vld  (sc_vld),
        .out_root (sc_len),
        .out_side (sc_side)
    );

    // ---------------- normalize forward ----------------
    mag_t sc_fm [3];
    assign sc_fm[0] = sc_side[3*DATA_W-1 -: DATA_W];
    assign sc_fm[1] = sc_side[2*DATA_W-1 -: DATA_W];
    assign sc_fm[2] = sc_side[DATA_W-1 -: DATA_W];

    localparam int DC_W = 5 + 6 * DATA_W;

    logic             s16_vld_reg, s16_fzero_reg;
    logic [DC_W-2:0]  s16_side_reg;
    acc_t             s16_num_reg [3];
    logic [DEN_W-1:0] s16_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s16_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s16_vld_reg <= sc_vld;
        end
    end

    // Flag a zero forward length, build dividends
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s16_fzero_reg <= (sc_len == '0);
            s16_side_reg  <= sc_side[SC_W-1 -: (DC_W-1)];
            for (int i = 0; i < 3; i++)
            begin
                s16_num_reg[i] <= (acc_t'(sc_fm[i]) << (OUT_FRAC_BITS + 1)) + acc_t'(sc_len);
            end
            s16_den_reg <= {sc_len, 1'b0};
        end
    end

    logic             dc_vld;
    logic [QUO_W-1:0] dc_quo [3];
    logic [DC_W-1:0]  dc_side;

    ofd_div #(.LANES(3), .NUM_W(ACC_W), .DEN_W(DEN_W), .QUO_W(QUO_W), .SIDE_W(DC_W)) u_div_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s16_vld_reg),
        .in_num   (s16_num_reg),
        .in_den   (s16_den_reg),
        .in_side  ({s16_side_reg[DC_W-2 -: 4], s16_fzero_reg, s16_side_reg[6*DATA_W-1:0]}),
        .out_vld  (dc_vld),
        .out_quo  (dc_quo),
        .out_side (dc_side)
    );

    // ---------------- output register ----------------
    logic  dc_bad, dc_fzero;
    logic [2:0] dc_fneg;
    comp_t dc_u [3];
    comp_t dc_r [3];

    assign dc_bad   = dc_side[DC_W-1];
    assign dc_fneg  = dc_side[DC_W-2 -: 3];
    assign dc_fzero = dc_side[6*DATA_W];
    assign dc_u[0]  = dc_side[6*DATA_W-1 -: DATA_W];
    assign dc_u[1]  = dc_side[5*DATA_W-1 -: DATA_W];
    assign dc_u[2]  = dc_side[4*DATA_W-1 -: DATA_W];
    assign dc_r[0]  = dc_side[3*DATA_W-1 -: DATA_W];
    assign dc_r[1]  = dc_side[2*DATA_W-1 -: DATA_W];
    assign dc_r[2]  = dc_side[DATA_W-1 -: DATA_W];

    logic  out_vld_reg, out_ok_reg;
    comp_t out_r_reg [3];
    comp_t out_u_reg [3];
    comp_t out_f_reg [3];

    // Advance the whole pipeline unless a finished frame is held
    assign adv          = !out_vld_reg || frame_out.ready;
    assign dir_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= dc_vld;
        end
    end

    // Zero every row of a rejected frame
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_ok_reg <= !dc_bad;
            for (int i = 0; i < 3; i++)
            begin
                out_r_reg[i] <= dc_bad ? '0 : dc_r[i];
                out_u_reg[i] <= dc_bad ? '0 : dc_u[i];
                out_f_reg[i] <= (dc_bad || dc_fzero) ? '0 : apply_sign(dc_quo[i], dc_fneg[i]);
            end
        end
    end

    assign frame_out.valid     = out_vld_reg;
    assign frame_out.valid_res = out_ok_reg;
    assign frame_out.right_x   = out_r_reg[0];
    assign frame_out.right_y   = out_r_reg[1];
    assign frame_out.right_z   = out_r_reg[2];
    assign frame_out.up_x      = out_u_reg[0];
    assign frame_out.up_y      = out_u_reg[1];
    assign frame_out.up_z      = out_u_reg[2];
    assign frame_out.fwd_x     = out_f_reg[0];
    assign frame_out.fwd_y     = out_f_reg[1];
    assign frame_out.fwd_z     = out_f_reg[2];
endmodule
